/* design/nand_flash_plane_program_erase_top_assert.svh */
// ----------------------------------------------------------------------------
// NAND flash plane block assertion macros
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef NAND_FLASH_PLANE_PROGRAM_ERASE_TOP_ASSERT_SVH
`define NAND_FLASH_PLANE_PROGRAM_ERASE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define NFPE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nfpe assertion failed");
`define NFPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nfpe assertion failed");
`else
`define NFPE_ASSERT_SAME(lbl, ante, cons)
`define NFPE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* design/nfpe_pkg.sv */
// ----------------------------------------------------------------------------
// NAND flash plane package
// Shared constants, command codes and address helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package nfpe_pkg;

  localparam int NFPE_ADDR_BITS = 26;
  localparam int PLANE_COUNT    = 4;
  localparam int PAGE_BYTES     = 'h200;
  localparam int SPARE_PER_PAGE = 'h10;
  localparam int BUF_BYTES      = PAGE_BYTES + SPARE_PER_PAGE;
  localparam int BLOCK_BYTES    = 'h4000;
  localparam int BUF_DEPTH      = PLANE_COUNT * BUF_BYTES;
  localparam int BUF_AW         = $clog2(BUF_DEPTH);
  localparam logic [7:0] STATUS_BYTE = 8'hC0;

  typedef enum logic [2:0] {
    K_READ   = 3'd0,
    K_BUFWR  = 3'd1,
    K_QPROG  = 3'd2,
    K_COMMIT = 3'd3,
    K_QERASE = 3'd4,
    K_ERASE  = 3'd5,
    K_STATUS = 3'd6,
    K_NONE   = 3'd7
  } kind_t;

  // Entry of a plane buffer: plane * 528 + index, as shifts and adds.
  function automatic logic [BUF_AW-1:0] buf_addr(input logic [1:0] plane,
                                                 input logic [9:0] idx);
    logic [BUF_AW-1:0] a;
    a = {1'b0, plane, 9'd0} + {6'd0, plane, 4'd0} + {2'd0, idx};
    return a;
  endfunction

endpackage

/* design/nfpe_ram.sv */
// ----------------------------------------------------------------------------
// NAND flash plane RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module nfpe_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/nand_flash_plane_program_erase_top.sv */
// A read request in range goes from execute through a data read to finish, any other
// short request from execute to finish; the next request is taken in the cycle after
// the result is loaded, and the result is only loaded once the output register is free.
// Commit reads each byte, then writes it back ANDed with the buffer, up to 4 x 528
// bytes; erase execute writes one byte a cycle, 16384 per queued plane. Synchronous
// active-low reset; clearing pass over every address (0xFF array, zero plane buffers).
`timescale 1ns / 1ps
`include "nand_flash_plane_program_erase_top_assert.svh"
// ----------------------------------------------------------------------------
// NAND flash plane program/erase top
// Four-plane NAND flash with page buffers, queued program and block erase.
// ----------------------------------------------------------------------------
module nand_flash_plane_program_erase_top
  import nfpe_pkg::*;
#(
  parameter int ADDR_BITS = NFPE_ADDR_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: page_offset in cfg_data[8:0].
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // kind[2:0], flash_address[28:3], byte_index[38:29], write_byte[46:39]
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_byte[7:0], pending_planes[11:8]
  output logic [15:0] out_tdata
);

  localparam int AB    = ADDR_BITS;
  localparam int SAW   = AB - 5;
  localparam int FDEP  = 1 << AB;
  localparam int SDEP  = 1 << SAW;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_EXEC  = 10'b0000000100,
    S_RDATA = 10'b0000001000,
    S_CSEL  = 10'b0000010000,
    S_CRD   = 10'b0000100000,
    S_CWR   = 10'b0001000000,
    S_ESEL  = 10'b0010000000,
    S_EWR   = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  state_t           state_r, state_nxt;
  kind_t            it_kind_r;
  logic [AB-1:0]    it_addr_r;
  logic [9:0]       it_idx_r;
  logic [7:0]       it_wb_r;
  logic [8:0]       off_r;
  logic [AB-1:0]    clr_r, clr_nxt;
  logic [13:0]      cnt_r, cnt_nxt;
  logic [1:0]       p_r, p_nxt;
  logic [3:0]       pend_r, pend_nxt;
  logic [3:0]       ep_r, ep_nxt;
  logic [AB-1:0]    bpa_r [PLANE_COUNT];
  logic [AB-1:0]    bpa_nxt [PLANE_COUNT];
  logic [AB-1:0]    eba_r [PLANE_COUNT];
  logic [AB-1:0]    eba_nxt [PLANE_COUNT];
  logic [7:0]       rd_r, rd_nxt;
  logic             out_valid_r;
  logic [7:0]       out_rd_r;
  logic [3:0]       out_pend_r;

  logic             in_acc, slot_free;
  logic [1:0]       it_plane, sel_plane;
  logic [AB-1:0]    sel_bpa, sel_eba, rd_base;
  logic [9:0]       rd_off;
  logic [10:0]      bw_pos;

  // Memory ports.
  logic             f_we, s_we, b_we;
  logic [AB-1:0]    f_waddr, f_raddr;
  logic [SAW-1:0]   s_waddr, s_raddr;
  logic [BUF_AW-1:0] b_waddr, b_raddr;
  logic [7:0]       f_wdata, s_wdata, b_wdata, f_q, s_q, b_q;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_pend_r, out_rd_r};

  // The per-plane address registers are read at one plane at a time: the
  // command's plane while it executes, else the plane being swept.
  assign it_plane  = it_addr_r[15:14];
  assign sel_plane = (state_r == S_EXEC) ? it_plane : p_r;
  assign sel_bpa   = bpa_r[sel_plane];
  assign sel_eba   = eba_r[sel_plane];

  // Read addressing shared by byte reads and the commit sweep. Page bytes wrap
  // in the array; spare bytes sit sixteen per page, so the low nine address
  // bits drop out and the spare index fills the low four.
  assign rd_base = (state_r == S_EXEC) ? it_addr_r : sel_bpa;
  assign rd_off  = (state_r == S_EXEC) ? it_idx_r : cnt_r[9:0];
  assign f_raddr = rd_base + AB'(rd_off);
  assign s_raddr = {rd_base[AB-1:9], rd_off[3:0]};
  assign b_raddr = buf_addr(p_r, cnt_r[9:0]);

  assign bw_pos = {2'd0, off_r} + {1'b0, it_idx_r};

  nfpe_ram #(.W(8), .DEPTH(FDEP)) u_flash (
    .clk(clk), .wr_en(f_we), .wr_addr(f_waddr), .wr_data(f_wdata),
    .rd_addr(f_raddr), .rd_data(f_q)
  );

  nfpe_ram #(.W(8), .DEPTH(SDEP)) u_spare (
    .clk(clk), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
    .rd_addr(s_raddr), .rd_data(s_q)
  );

  nfpe_ram #(.W(8), .DEPTH(BUF_DEPTH)) u_buf (
    .clk(clk), .wr_en(b_we), .wr_addr(b_waddr), .wr_data(b_wdata),
    .rd_addr(b_raddr), .rd_data(b_q)
  );

  // Write ports: clearing pass, commit write-back, erase sweep, buffer write.
  always_comb begin
    f_we    = 1'b0;
    f_waddr = f_raddr;
    f_wdata = 8'hFF;
    s_we    = 1'b0;
    s_waddr = s_raddr;
    s_wdata = 8'hFF;
    b_we    = 1'b0;
    b_waddr = buf_addr(it_plane, it_idx_r);
    b_wdata = it_wb_r;
    case (state_r)
      S_CLEAR: begin
        f_we    = 1'b1;
        f_waddr = clr_r;
        s_we    = (clr_r[AB-1:SAW] == '0);
        s_waddr = clr_r[SAW-1:0];
        b_we    = (clr_r < AB'(BUF_DEPTH));
        b_waddr = clr_r[BUF_AW-1:0];
        b_wdata = 8'd0;
      end
      S_CWR: begin
        // Bits only go from one to zero when programming.
        f_we    = !cnt_r[9];
        f_wdata = f_q & b_q;
        s_we    = cnt_r[9];
        s_wdata = s_q & b_q;
      end
      S_EWR: begin
        f_we    = 1'b1;
        f_waddr = {sel_eba[AB-1:14], cnt_r};
        s_we    = (cnt_r[13:9] == 5'd0);
        s_waddr = {sel_eba[AB-1:14], cnt_r[8:0]};
      end
      S_EXEC: begin
        if (it_kind_r == K_BUFWR) begin
          if (it_idx_r < 10'(PAGE_BYTES)) begin
            b_we    = (bw_pos < 11'(PAGE_BYTES));
            b_waddr = buf_addr(it_plane, bw_pos[9:0]);
          end else begin
            b_we    = (it_idx_r < 10'(BUF_BYTES));
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cnt_nxt   = cnt_r;
    p_nxt     = p_r;
    pend_nxt  = pend_r;
    ep_nxt    = ep_r;
    rd_nxt    = rd_r;
    bpa_nxt   = bpa_r;
    eba_nxt   = eba_r;
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        rd_nxt    = 8'd0;
        state_nxt = S_FIN;
        case (it_kind_r)
          K_READ: begin
            if (it_idx_r >= {1'b0, off_r} && it_idx_r < 10'(BUF_BYTES)) begin
              state_nxt = S_RDATA;
            end
          end
          K_BUFWR: begin
            bpa_nxt[it_plane] = it_addr_r;
          end
          K_QPROG, K_COMMIT: begin
            if (sel_bpa == it_addr_r) begin
              pend_nxt[it_plane] = 1'b1;
            end
            if (it_kind_r == K_COMMIT) begin
              p_nxt     = 2'd0;
              state_nxt = S_CSEL;
            end
          end
          K_QERASE: begin
            eba_nxt[it_plane] = {it_addr_r[AB-1:14], 14'd0};
            ep_nxt[it_plane]  = 1'b1;
          end
          K_ERASE: begin
            p_nxt     = 2'd0;
            state_nxt = S_ESEL;
          end
          K_STATUS: begin
            rd_nxt = STATUS_BYTE;
          end
          default: begin
          end
        endcase
      end
      S_RDATA: begin
        rd_nxt    = it_idx_r[9] ? s_q : f_q;
        state_nxt = S_FIN;
      end
      S_CSEL: begin
        if (pend_r[p_r]) begin
          cnt_nxt   = {5'd0, off_r};
          state_nxt = S_CRD;
        end else if (p_r == 2'd3) begin
          state_nxt = S_FIN;
        end else begin
          p_nxt = p_r + 1'b1;
        end
      end
      S_CRD: begin
        state_nxt = S_CWR;
      end
      S_CWR: begin
        if (cnt_r[9:0] == 10'(BUF_BYTES - 1)) begin
          pend_nxt[p_r] = 1'b0;
          if (p_r == 2'd3) begin
            state_nxt = S_FIN;
          end else begin
            p_nxt     = p_r + 1'b1;
            state_nxt = S_CSEL;
          end
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_CRD;
        end
      end
      S_ESEL: begin
        if (ep_r[p_r]) begin
          cnt_nxt   = 14'd0;
          state_nxt = S_EWR;
        end else if (p_r == 2'd3) begin
          state_nxt = S_FIN;
        end else begin
          p_nxt = p_r + 1'b1;
        end
      end
      S_EWR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (&cnt_r) begin
          ep_nxt[p_r] = 1'b0;
          if (p_r == 2'd3) begin
            state_nxt = S_FIN;
          end else begin
            p_nxt     = p_r + 1'b1;
            state_nxt = S_ESEL;
          end
        end
      end
      S_FIN: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      p_r         <= '0;
      pend_r      <= '0;
      ep_r        <= '0;
      off_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < PLANE_COUNT; i++) begin
        bpa_r[i] <= '0;
        eba_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      p_r     <= p_nxt;
      pend_r  <= pend_nxt;
      ep_r    <= ep_nxt;
      bpa_r   <= bpa_nxt;
      eba_r   <= eba_nxt;
      if (cfg_valid && cfg_ready) begin
        off_r <= cfg_data[8:0];
      end
      if (state_r == S_FIN && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_r <= rd_nxt;
    if (in_acc) begin
      it_kind_r <= kind_t'(in_tdata[2:0]);
      it_addr_r <= AB'(in_tdata[28:3]);
      it_idx_r  <= in_tdata[38:29];
      it_wb_r   <= in_tdata[46:39];
    end
    if (state_r == S_FIN && slot_free) begin
      out_rd_r   <= rd_r;
      out_pend_r <= pend_r;
    end
  end

  `NFPE_ASSERT_SAME(a_no_accept_clear, state_r == S_CLEAR, !in_tready)
  `NFPE_ASSERT_NEXT(a_accept_exec, in_acc, state_r == S_EXEC)
  `NFPE_ASSERT_SAME(a_commit_drains, state_r == S_FIN && it_kind_r == K_COMMIT, pend_r == 4'd0)
  `NFPE_ASSERT_SAME(a_erase_drains, state_r == S_FIN && it_kind_r == K_ERASE, ep_r == 4'd0)

endmodule
